### hdl/rasp_pkg.sv
// Shared types and constants for the rotated array pivot and search block.
package rasp_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_PIVOT  = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef logic signed [DATA_W-1:0] elem_t;

endpackage

### hdl/rasp_mem.sv
// Element memory: one write port, two read ports, registered read data.
module rasp_mem #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  rasp_pkg::elem_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output rasp_pkg::elem_t          rdata_a,
    output rasp_pkg::elem_t          rdata_b
);

    rasp_pkg::elem_t mem [DEPTH];
    rasp_pkg::elem_t rdata_a_reg;
    rasp_pkg::elem_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hdl/rotated_array_pivot_and_search.sv
// Top level: element store with pivot search and range binary search.
//
// Requests are taken when start is high and busy is low. A load request writes one
// element (index wrapped modulo DEPTH) and never raises busy, so loads can be
// issued back to back; it gives no result. A pivot or search request raises busy
// and bisects the store; each probe issues its address in a check state and compares
// the registered read data of the element memory in an evaluate state. A pivot
// first fetches the first element in its own state, but stops once its window is a
// single entry. A pivot with element_count 0 answers in the next cycle without
// going busy. The result sits on result_index/found for exactly one cycle with done
// high; the receiver cannot stall it, and a new request may be taken in that same
// cycle. element_count is written over the APB port at address 0 and should only
// change while the block is idle.
module rotated_array_pivot_and_search #(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [7:0]         load_index,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] target,
    input  logic [8:0]         range_start,
    input  logic signed [8:0]  range_end,
    // result channel
    output logic               done,
    output logic [7:0]         result_index,
    output logic               found,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(DEPTH);
    // index math width: holds 9-bit request fields, DEPTH, and a sign
    localparam int XW = ((AW > 9) ? AW : 9) + 2;
    localparam logic signed [XW-1:0] MAX_IDX = XW'(DEPTH - 1);
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIV_LO,
        ST_PIV_CHK,
        ST_PIV_EVAL,
        ST_SRCH_CHK,
        ST_SRCH_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   lo_load_reg, lo_load_next;
    logic [8:0] count_reg;

    logic signed [XW-1:0] lo_reg, lo_next;
    logic signed [XW-1:0] hi_reg, hi_next;
    logic signed [XW-1:0] mid_reg, mid_next;
    rasp_pkg::elem_t      lo_val_reg, lo_val_next;
    rasp_pkg::elem_t      key_reg, key_next;
    logic [7:0]           res_idx_reg, res_idx_next;
    logic                 found_reg, found_next;

    logic                 accept;
    logic                 cfg_write;
    logic [XW-1:0]        n_x;
    logic signed [XW-1:0] start_x;
    logic signed [XW-1:0] end_x;
    logic signed [XW-1:0] end_clamp;
    logic signed [XW-1:0] mid_calc;
    logic [XW-1:0]        mid_inc;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    rasp_pkg::elem_t      rdata_a;
    rasp_pkg::elem_t      rdata_b;

    // load index wrap, modulo DEPTH, as a constant table
    logic [AW-1:0] wrap_lut [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_wrap
        assign wrap_lut[g] = AW'(g % DEPTH);
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == rasp_pkg::REG_ELEMENT_COUNT) ? {23'd0, count_reg} : 32'd0;

    // ---------------- element store ----------------
    // Loads are only taken while idle and probes only run while busy, so a write
    // and a read of the same entry never share a cycle.
    assign mem_we    = accept && (action == rasp_pkg::ACT_LOAD);
    assign mem_waddr = wrap_lut[load_index];

    rasp_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (load_value),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    // ---------------- bisection datapath ----------------
    // pivot length: element_count capped at DEPTH
    assign n_x       = (XW'(count_reg) > DEPTH_X) ? DEPTH_X : XW'(count_reg);
    assign start_x   = $signed(XW'(range_start));
    assign end_x     = XW'(range_end);
    assign end_clamp = (end_x > MAX_IDX) ? MAX_IDX : end_x;

    // lo and hi are non-negative whenever a midpoint is used
    assign mid_calc = (lo_reg + hi_reg) >>> 1;
    assign mid_inc  = mid_calc + XW'(1);

    // port A: first element during ST_PIV_LO, else the midpoint; port B: mid+1
    assign raddr_a = (state_reg == ST_PIV_LO) ? '0 : mid_calc[AW-1:0];
    assign raddr_b = mid_inc[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        lo_load_next = lo_load_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        lo_val_next  = lo_val_reg;
        key_next     = key_reg;
        res_idx_next = res_idx_reg;
        found_next   = found_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        rasp_pkg::ACT_PIVOT:
                        begin
                            if (n_x == '0)
                            begin
                                res_idx_next = 8'd0;
                                found_next   = 1'b0;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = $signed(n_x - XW'(1));
                                state_next = ST_PIV_LO;
                            end
                        end
                        rasp_pkg::ACT_SEARCH:
                        begin
                            key_next   = target;
                            lo_next    = start_x;
                            hi_next    = end_clamp;
                            state_next = ST_SRCH_CHK;
                        end
                        default:
                        begin
                            // load handled by the write port; unused code ignored
                        end
                    endcase
                end
            end

            ST_PIV_LO:
            begin
                lo_load_next = 1'b1;
                state_next   = ST_PIV_CHK;
            end

            ST_PIV_CHK:
            begin
                if (lo_load_reg)
                begin
                    lo_val_next  = rdata_a;
                    lo_load_next = 1'b0;
                end
                if (lo_reg >= hi_reg)
                begin
                    res_idx_next = 8'(lo_reg);
                    found_next   = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = ST_PIV_EVAL;
                end
            end

            ST_PIV_EVAL:
            begin
                if (rdata_a > rdata_b)
                begin
                    // descent between mid and mid+1: mid holds the maximum
                    res_idx_next = 8'(mid_reg);
                    found_next   = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    if (lo_val_reg > rdata_a)
                    begin
                        hi_next = mid_reg - XW'(1);
                    end
                    else
                    begin
                        lo_next     = mid_reg + XW'(1);
                        lo_val_next = rdata_b;
                    end
                    state_next = ST_PIV_CHK;
                end
            end

            ST_SRCH_CHK:
            begin
                if (lo_reg > hi_reg)
                begin
                    res_idx_next = 8'd0;
                    found_next   = 1'b0;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = ST_SRCH_EVAL;
                end
            end

            ST_SRCH_EVAL:
            begin
                if (rdata_a == key_reg)
                begin
                    res_idx_next = 8'(mid_reg);
                    found_next   = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    if (key_reg > rdata_a)
                    begin
                        lo_next = mid_reg + XW'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg - XW'(1);
                    end
                    state_next = ST_SRCH_CHK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            lo_load_reg <= 1'b0;
            count_reg   <= 9'd1;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            lo_load_reg <= lo_load_next;
            if (cfg_write && (paddr[2] == rasp_pkg::REG_ELEMENT_COUNT))
            begin
                count_reg <= pwdata[8:0];
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        lo_val_reg  <= lo_val_next;
        key_reg     <= key_next;
        res_idx_reg <= res_idx_next;
        found_reg   <= found_next;
    end

    assign done         = done_reg;
    assign result_index = res_idx_reg;
    assign found        = found_reg;

    // ---------------- assertions ----------------
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !busy)
        else $error("element write while a query is running");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (result_index == 8'd0))
        else $error("miss reported with nonzero index");

    a_piv_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIV_EVAL) |-> ((mid_reg < hi_reg) && (mid_reg >= lo_reg)))
        else $error("pivot midpoint outside its window");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    a_srch_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_EVAL) |-> ((mid_reg >= 0) && (mid_reg <= MAX_IDX)))
        else $error("search probe outside the store");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the rotated array pivot and range search block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 256;
    localparam int CLK_PERIOD     = 10;
    localparam int TOTAL_ITEMS    = 1450;
    // Trailing wait before a write; longer than the longest pivot.
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 500_000;

    // Action code the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] index;
        logic       found;
    } answer_t;

    localparam answer_t NO_ANSWER = '0;

    typedef enum logic {
        ROW_REQ,
        ROW_COUNT
    } row_kind_t;

    // One directed step: a request, or a new element_count (value in lv).
    typedef struct {
        row_kind_t       kind;
        logic [1:0]      act;
        logic [7:0]      li;
        rasp_pkg::elem_t lv;
        rasp_pkg::elem_t tg;
        logic [8:0]      rs;
        logic [8:0]      re;
        logic            typed;
        answer_t         ans;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [7:0]         load_index;
    logic signed [31:0] load_value;
    logic signed [31:0] target;
    logic [8:0]         range_start;
    logic signed [8:0]  range_end;
    logic               done;
    logic [7:0]         result_index;
    logic               found;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Typed-in answer that travels with a directed request.
    logic               req_typed;
    answer_t            req_answer;

    // Predictor state: private copy of the element store and the register.
    rasp_pkg::elem_t    store_copy [DEPTH];
    logic [8:0]         count_copy;

    answer_t            pending_answers [$];
    int                 fail_count;
    int                 result_no;
    int                 items_sent;
    int                 idle_pct;

    stim_row_t          dir_table [26];

    rotated_array_pivot_and_search #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .load_index   (load_index),
        .load_value   (load_value),
        .target       (target),
        .range_start  (range_start),
        .range_end    (range_end),
        .done         (done),
        .result_index (result_index),
        .found        (found),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Bisect the first count_copy entries (capped at DEPTH) for the largest element.
    function automatic answer_t predict_pivot();
        int      n;
        int      lo;
        int      hi;
        int      mid;
        answer_t ans;
        ans = NO_ANSWER;
        n = int'(count_copy);
        if (n > DEPTH)
        begin
            n = DEPTH;
        end
        if (n == 0)
        begin
            return ans;
        end
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (lo == hi)
            begin
                break;
            end
            if (store_copy[mid] > store_copy[mid + 1])
            begin
                lo = mid;
                break;
            end
            if (store_copy[lo] > store_copy[mid])
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        ans.index = 8'(lo);
        ans.found = 1'b1;
        return ans;
    endfunction

    // Plain binary search over the inclusive range; end clamps to the last entry.
    function automatic answer_t predict_search(input rasp_pkg::elem_t key,
                                               input logic [8:0] lo_bound,
                                               input logic signed [8:0] hi_bound);
        int      lo;
        int      hi;
        int      mid;
        answer_t ans;
        ans = NO_ANSWER;
        lo = int'(lo_bound);
        hi = int'(hi_bound);
        if (hi > DEPTH - 1)
        begin
            hi = DEPTH - 1;
        end
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (store_copy[mid] == key)
            begin
                ans.index = 8'(mid);
                ans.found = 1'b1;
                return ans;
            end
            if (key > store_copy[mid])
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return ans;
    endfunction

    // Result checking and request tracking. Everything is sampled at the rising
    // edge, so outputs and driven inputs are both seen with their pre-edge values.
    always @(posedge clk)
    begin : result_monitor
        answer_t want;
        if (rst_n)
        begin
            // A result can share its edge with the next accepted request; it
            // always belongs to an older request, so check it first.
            if (done)
            begin
                result_no++;
                if (pending_answers.size() == 0)
                begin
                    note_failure($sformatf("result %0d with no request pending: index %0d found %b",
                                           result_no, result_index, found));
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (result_index !== want.index || found !== want.found)
                    begin
                        note_failure($sformatf(
                            "result %0d: expected index %0d found %b, got index %0d found %b",
                            result_no, want.index, want.found, result_index, found));
                    end
                end
            end
            if (start && !busy)
            begin
                case (action)
                    rasp_pkg::ACT_LOAD:
                    begin
                        store_copy[load_index] = load_value;
                    end
                    rasp_pkg::ACT_PIVOT:
                    begin
                        pending_answers.push_back(req_typed ? req_answer : predict_pivot());
                    end
                    rasp_pkg::ACT_SEARCH:
                    begin
                        pending_answers.push_back(req_typed ? req_answer :
                                                  predict_search(target, range_start, range_end));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Present one request and hold it until the block takes it. The sender may
    // idle first; start is lowered only in steps where it is not raised.
    task automatic send_request(input logic [1:0] act, input logic [7:0] idx,
                                input rasp_pkg::elem_t value, input rasp_pkg::elem_t key,
                                input logic [8:0] lo, input logic [8:0] hi,
                                input logic typed, input answer_t ans);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        load_index  <= idx;
        load_value  <= value;
        target      <= key;
        range_start <= lo;
        range_end   <= hi;
        req_typed   <= typed;
        req_answer  <= ans;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        if (act != ACT_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Wait until every request has answered, then give a trailing load time to land.
    task automatic settle();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == rasp_pkg::REG_ELEMENT_COUNT)
        begin
            count_copy = value[8:0];
        end
    endtask

    // Run time limit.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main stimulus.
    initial
    begin : stimulus
        longint          ladder [DEPTH];
        rasp_pkg::elem_t shadow [DEPTH];
        rasp_pkg::elem_t key;
        rasp_pkg::elem_t value;
        longint          acc;
        logic [8:0]      lo_bits;
        logic [8:0]      hi_bits;
        logic [8:0]      count_val;
        int              n_eff;
        int              rot;
        int              pivot_at;
        int              lo_q;
        int              hi_q;
        int              pick;
        int              choice;
        int              step_cap;
        int              phase_no;
        int              idx;
        int              w;

        fail_count  = 0;
        result_no   = 0;
        items_sent  = 0;
        idle_pct    = 0;
        count_copy  = 9'd1;
        phase_no    = 0;

        rst_n       = 1'b0;
        start       = 1'b0;
        action      = rasp_pkg::ACT_LOAD;
        load_index  = '0;
        load_value  = '0;
        target      = '0;
        range_start = '0;
        range_end   = '0;
        req_typed   = 1'b0;
        req_answer  = NO_ANSWER;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        // Directed steps. Fill below leaves entry i = 16*i - 2048, ascending,
        // so the early pivot and miss answers can be typed in directly.
        dir_table = '{
            // element_count is 1 out of reset: trivial pivot at 0
            '{ROW_REQ, rasp_pkg::ACT_PIVOT, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b1,
              '{8'd0, 1'b1}},
            // zero count: no pivot
            '{ROW_COUNT, rasp_pkg::ACT_LOAD, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_PIVOT, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b1,
              '{8'd0, 1'b0}},
            // full store, not rotated: pivot is the last entry
            '{ROW_COUNT, rasp_pkg::ACT_LOAD, 8'd0, 32'sd256, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_PIVOT, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b1,
              '{8'd255, 1'b1}},
            // count above the store size is capped
            '{ROW_COUNT, rasp_pkg::ACT_LOAD, 8'd0, 32'sd511, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_PIVOT, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b1,
              '{8'd255, 1'b1}},
            // hit on a filled entry
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, -32'sd1456, 9'd0, 9'd255, 1'b0,
              NO_ANSWER},
            // empty ranges: end below start, end of -1, start past the store
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, -32'sd1888, 9'd10, 9'd9, 1'b1,
              '{8'd0, 1'b0}},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, -32'sd2048, 9'd0, 9'h1FF, 1'b1,
              '{8'd0, 1'b0}},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'sd2032, 9'd256, 9'd255, 1'b1,
              '{8'd0, 1'b0}},
            // extreme targets, not present yet
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'h7FFF_FFFF, 9'd0, 9'd255, 1'b1,
              '{8'd0, 1'b0}},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'h8000_0000, 9'd0, 9'd255, 1'b1,
              '{8'd0, 1'b0}},
            // extreme values at both ends keep the store ascending
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd255, 32'h7FFF_FFFF, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd0, 32'h8000_0000, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'h7FFF_FFFF, 9'd0, 9'd255, 1'b1,
              '{8'd255, 1'b1}},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'h8000_0000, 9'd0, 9'd255, 1'b0,
              NO_ANSWER},
            // unused action code: no result
            '{ROW_REQ, ACT_UNUSED, 8'hA5, 32'sd7, 32'sd7, 9'h155, 9'h0AA, 1'b0,
              NO_ANSWER},
            // small rotated array 30 40 10 20: pivot at 1
            '{ROW_COUNT, rasp_pkg::ACT_LOAD, 8'd0, 32'sd4, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd0, 32'sd30, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd1, 32'sd40, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd2, 32'sd10, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_LOAD, 8'd3, 32'sd20, 32'sd0, 9'd0, 9'd0, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_PIVOT, 8'd0, 32'sd0, 32'sd0, 9'd0, 9'd0, 1'b1,
              '{8'd1, 1'b1}},
            // search each sorted half
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'sd10, 9'd2, 9'd3, 1'b0,
              NO_ANSWER},
            '{ROW_REQ, rasp_pkg::ACT_SEARCH, 8'd0, 32'sd0, 32'sd40, 9'd0, 9'd1, 1'b0,
              NO_ANSWER}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write every entry once so no request can ever probe an unwritten one.
        for (idx = 0; idx < DEPTH; idx++)
        begin
            shadow[idx] = rasp_pkg::elem_t'(idx * 16 - 2048);
            send_request(rasp_pkg::ACT_LOAD, 8'(idx), shadow[idx], '0, '0, '0, 1'b0, NO_ANSWER);
        end

        foreach (dir_table[r])
        begin
            if (dir_table[r].kind == ROW_COUNT)
            begin
                settle();
                write_register(rasp_pkg::REG_ELEMENT_COUNT, dir_table[r].lv);
            end
            else
            begin
                if (dir_table[r].act == rasp_pkg::ACT_LOAD)
                begin
                    shadow[dir_table[r].li] = dir_table[r].lv;
                end
                send_request(dir_table[r].act, dir_table[r].li, dir_table[r].lv, dir_table[r].tg,
                             dir_table[r].rs, dir_table[r].re, dir_table[r].typed,
                             dir_table[r].ans);
            end
        end

        // Random phases: each drains, sets a new count, then either loads a fresh
        // rotated ascending array and queries it, or throws noise at the block.
        while (items_sent < TOTAL_ITEMS)
        begin
            phase_no++;
            case (phase_no % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 83;
                default: idle_pct = 12;
            endcase

            // The drain before the write doubles as the full pause of the sender.
            settle();
            choice = $urandom_range(39);
            if (choice == 0)
                count_val = 9'd0;
            else if (choice == 1)
                count_val = 9'd1;
            else if (choice == 2)
                count_val = 9'd256;
            else if (choice == 3)
                count_val = 9'($urandom_range(257, 511));
            else if (choice <= 5)
                count_val = 9'd2;
            else if (choice <= 8)
                count_val = 9'($urandom_range(17, 64));
            else
                count_val = 9'($urandom_range(3, 16));
            write_register(rasp_pkg::REG_ELEMENT_COUNT, {23'($urandom), count_val});

            n_eff = (int'(count_val) > DEPTH) ? DEPTH : int'(count_val);

            if (n_eff >= 1 && $urandom_range(4) != 0)
            begin
                // Strictly ascending ladder, rotated left by rot.
                step_cap = 1 << $urandom_range(0, 20);
                acc = longint'($signed($urandom)) >>> 1;
                for (idx = 0; idx < n_eff; idx++)
                begin
                    ladder[idx] = acc;
                    acc += longint'($urandom_range(1, step_cap));
                end
                rot = $urandom_range(n_eff - 1);
                for (idx = 0; idx < n_eff; idx++)
                begin
                    shadow[idx] = rasp_pkg::elem_t'(ladder[(idx + rot) % n_eff]);
                    send_request(rasp_pkg::ACT_LOAD, 8'(idx), shadow[idx], '0, '0, '0, 1'b0,
                                 NO_ANSWER);
                end
                pivot_at = n_eff - 1 - rot;

                repeat ($urandom_range(6, 14))
                begin
                    choice = $urandom_range(29);
                    if (choice < 7)
                    begin
                        send_request(rasp_pkg::ACT_PIVOT, '0, '0, '0, '0, '0, 1'b0, NO_ANSWER);
                    end
                    else if (choice == 7)
                    begin
                        send_request(ACT_UNUSED, 8'($urandom), $urandom, $urandom,
                                     9'($urandom), 9'($urandom), 1'b0, NO_ANSWER);
                    end
                    else
                    begin
                        // Pick one sorted half, sometimes a slice of it.
                        if ($urandom_range(1) == 0 || pivot_at == n_eff - 1)
                        begin
                            lo_q = 0;
                            hi_q = pivot_at;
                        end
                        else
                        begin
                            lo_q = pivot_at + 1;
                            hi_q = n_eff - 1;
                        end
                        if ($urandom_range(9) < 3)
                        begin
                            lo_q = $urandom_range(lo_q, hi_q);
                            hi_q = $urandom_range(lo_q, hi_q);
                        end
                        pick = $urandom_range(lo_q, hi_q);
                        choice = $urandom_range(19);
                        if (choice < 14)
                            key = shadow[pick];
                        else if (choice < 17)
                            key = shadow[pick] + 32'sd1;
                        else
                            key = $urandom;
                        lo_bits = 9'(lo_q);
                        hi_bits = 9'(hi_q);
                        // Now and then a broken range.
                        if ($urandom_range(14) == 0)
                        begin
                            lo_bits = 9'($urandom);
                            hi_bits = 9'($urandom);
                        end
                        send_request(rasp_pkg::ACT_SEARCH, '0, '0, key, lo_bits, hi_bits, 1'b0,
                                     NO_ANSWER);
                    end
                end
            end
            else
            begin
                // Noise: scattered loads of any value, arbitrary ranges and targets.
                repeat ($urandom_range(8, 30))
                begin
                    choice = $urandom_range(19);
                    if (choice < 8)
                    begin
                        idx = $urandom_range(DEPTH - 1);
                        value = $urandom;
                        shadow[idx] = value;
                        send_request(rasp_pkg::ACT_LOAD, 8'(idx), value, $urandom, 9'($urandom),
                                     9'($urandom), 1'b0, NO_ANSWER);
                    end
                    else if (choice < 11)
                    begin
                        send_request(rasp_pkg::ACT_PIVOT, 8'($urandom), $urandom, $urandom,
                                     9'($urandom), 9'($urandom), 1'b0, NO_ANSWER);
                    end
                    else if (choice < 19)
                    begin
                        key = ($urandom_range(1) == 0) ? shadow[$urandom_range(DEPTH - 1)]
                                                        : rasp_pkg::elem_t'($urandom);
                        if ($urandom_range(1) == 0)
                        begin
                            lo_bits = 9'($urandom);
                            hi_bits = 9'($urandom);
                        end
                        else
                        begin
                            lo_q = $urandom_range(DEPTH - 1);
                            hi_q = $urandom_range(lo_q, DEPTH - 1);
                            lo_bits = 9'(lo_q);
                            hi_bits = 9'(hi_q);
                        end
                        send_request(rasp_pkg::ACT_SEARCH, 8'($urandom), $urandom, key, lo_bits,
                                     hi_bits, 1'b0, NO_ANSWER);
                    end
                    else
                    begin
                        send_request(ACT_UNUSED, 8'($urandom), $urandom, $urandom,
                                     9'($urandom), 9'($urandom), 1'b0, NO_ANSWER);
                    end
                end
            end
        end

        // Final drain with a bound, then a tail for any stray result.
        start <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_answers.size() != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            note_failure($sformatf("%0d requests never answered", pending_answers.size()));
        end

        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
